// ===== sv/hsdd_pkg.sv =====
// hsdd_pkg: sizes, memory entry type and the controller/datapath command
// and status structs of the hash set duplicate detector
// no dependencies
package hsdd_pkg;

  // bucket count, a power of two of at least 2; the bucket is the low bits
  localparam int NUM_BUCKETS = 1024;
  // node pool entries
  localparam int POOL_SIZE   = 1024;

  localparam int VALUE_W  = 32;
  localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IDX_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  // links and the fill count hold 0..POOL_SIZE, 0 meaning null
  localparam int LINK_W   = $clog2(POOL_SIZE + 1);

  // one pool node: stored value and link to the next node (index + 1)
  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic [LINK_W-1:0]  link;
  } node_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input transaction, read the bucket head
    logic head_chk;   // head read data is present
    logic node_rd;    // read the node that the candidate link points at
    logic node_chk;   // node read data is present
    logic set_found;  // value matched a stored node
    logic insert;     // link the value in, or flag the pool as full
    logic load_out;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic link_ok;    // candidate link is non-null and allocated
    logic match;      // node value equals the item value
    logic stale;      // head points at a node of another bucket
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// ===== sv/hsdd_if.sv =====
// hsdd_item_if / hsdd_result_if: valid/ready channels of the detector
// depends on hsdd_pkg for the value width
interface hsdd_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [hsdd_pkg::VALUE_W-1:0] value;
  logic                                first_of_set;
  logic                                last_of_set;

  modport source (output valid, value, first_of_set, last_of_set, input ready);
  modport sink   (input valid, value, first_of_set, last_of_set, output ready);
endinterface

interface hsdd_result_if;
  logic valid;
  logic ready;
  logic seen_before;
  logic any_duplicate;
  logic table_full;
  logic set_done;

  modport source (output valid, seen_before, any_duplicate, table_full, set_done,
                  input ready);
  modport sink   (input valid, seen_before, any_duplicate, table_full, set_done,
                  output ready);
endinterface

// ===== sv/hash_set_duplicate_detector_core.sv =====
// hash_set_duplicate_detector_core: top level joining controller and
// datapath; depends on hsdd_pkg, hsdd_if, hsdd_ctrl and hsdd_datapath
//
// Usage
//   item:   valid/ready channel carrying value, first_of_set, last_of_set.
//           first_of_set empties the stored set and the sticky duplicate
//           flag before the value is looked up.
//   result: valid/ready channel, one transaction per item: seen_before,
//           any_duplicate (sticky for the set), table_full (value new but
//           the node pool exhausted) and set_done (echo of last_of_set).
//   One item is processed at a time. An item reads its bucket head, then
//   walks the bucket chain one node per cycle through the one read port of
//   the node pool, and inserts the value if it is not found. The result
//   then moves into the output register.
//   Reset empties the set at once; no clearing pass is needed, since stale
//   bucket heads are recognised by checking the node they point at.
//   When the receiver stalls, the finished result waits in the output
//   register; the next item is still accepted and walked, and its result
//   waits in the datapath item registers until the output register frees.
module hash_set_duplicate_detector_core (
  input  logic          clk,
  input  logic          rst,
  hsdd_item_if.sink     item,
  hsdd_result_if.source result
);
  import hsdd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign item.ready = in_ready;

  // sequencing
  hsdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result
  hsdd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .item_value (item.value),
    .item_first (item.first_of_set),
    .item_last  (item.last_of_set),
    .result     (result)
  );

endmodule

// ===== sv/hsdd_ctrl.sv =====
// hsdd_ctrl: state machine that sequences the bucket head read, the chain
// walk, the insert and the result hand-off; depends on hsdd_pkg
module hsdd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsdd_pkg::sts_t sts,
  output hsdd_pkg::cmd_t cmd
);
  import hsdd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_NODE   = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_chk = 1'b1;
        if (sts.link_ok) begin
          cmd.node_rd = 1'b1;
          state_next  = S_NODE;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_NODE: begin
        cmd.node_chk = 1'b1;
        if (sts.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_DONE;
        end else if (sts.stale) begin
          state_next = S_INSERT;
        end else if (sts.link_ok) begin
          cmd.node_rd = 1'b1;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  a_found_xor_insert: assert property (@(posedge clk) disable iff (rst)
    !(cmd.set_found && cmd.insert))
    else $error("match and insert in the same cycle");

  a_insert_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (state == S_DONE))
    else $error("insert not followed by result hand-off");

  a_accept_then_head: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_HEAD))
    else $error("accepted transaction did not start a head read");

endmodule

// ===== sv/hsdd_datapath.sv =====
// hsdd_datapath: bucket head and node pool memories, fill count, sticky
// duplicate flag and output register; depends on hsdd_pkg and hsdd_if
module hsdd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  hsdd_pkg::cmd_t                      cmd,
  output hsdd_pkg::sts_t                      sts,
  input  logic signed [hsdd_pkg::VALUE_W-1:0] item_value,
  input  logic                                item_first,
  input  logic                                item_last,
  hsdd_result_if.source                       result
);
  import hsdd_pkg::*;

  // memories, no reset: head entries are checked against the node they name
  logic [LINK_W-1:0] head_mem [NUM_BUCKETS];
  node_t             node_mem [POOL_SIZE];

  logic [LINK_W-1:0]  head_rd_q;
  node_t              node_rd_q;

  logic [VALUE_W-1:0] value_q;
  logic               last_q;
  logic [LINK_W-1:0]  nodes_used;
  logic               dup_seen;
  logic [LINK_W-1:0]  cand_head;
  logic               head_valid;
  logic               first_visit;
  logic               found_q;
  logic               full_q;

  logic [BUCKET_W-1:0] bucket_q;
  logic [LINK_W-1:0]   next_link;
  logic [LINK_W-1:0]   link_m1;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [LINK_W-1:0]   ins_link;
  logic                pool_full;
  logic                do_write;

  assign bucket_q  = value_q[BUCKET_W-1:0];
  assign pool_full = (nodes_used == LINK_W'(POOL_SIZE));
  assign do_write  = cmd.insert && !pool_full;
  assign wr_idx    = nodes_used[IDX_W-1:0];
  assign ins_link  = head_valid ? cand_head : '0;

  // candidate link comes from the head read, then from each visited node
  assign next_link = cmd.head_chk ? head_rd_q : node_rd_q.link;
  assign link_m1   = next_link - LINK_W'(1);
  assign rd_idx    = link_m1[IDX_W-1:0];

  // status for the controller
  always_comb begin
    sts.link_ok  = (next_link != '0) && (next_link <= nodes_used);
    sts.match    = (node_rd_q.val == value_q);
    sts.stale    = first_visit && (node_rd_q.val[BUCKET_W-1:0] != bucket_q);
    sts.out_free = !result.valid || result.ready;
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      head_rd_q <= head_mem[item_value[BUCKET_W-1:0]];
    end
    if (do_write) begin
      head_mem[bucket_q] <= nodes_used + LINK_W'(1);
    end
  end

  // node pool memory
  always_ff @(posedge clk) begin
    if (cmd.node_rd) begin
      node_rd_q <= node_mem[rd_idx];
    end
    if (do_write) begin
      node_mem[wr_idx] <= '{val: value_q, link: ins_link};
    end
  end

  // item registers and walk bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used  <= '0;
      dup_seen    <= 1'b0;
      head_valid  <= 1'b0;
      first_visit <= 1'b0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        value_q <= $unsigned(item_value);
        last_q  <= item_last;
        found_q <= 1'b0;
        full_q  <= 1'b0;
        if (item_first) begin
          nodes_used <= '0;
          dup_seen   <= 1'b0;
        end
      end
      if (cmd.head_chk) begin
        cand_head   <= head_rd_q;
        head_valid  <= sts.link_ok;
        first_visit <= 1'b1;
      end
      if (cmd.node_chk) begin
        first_visit <= 1'b0;
        if (sts.stale) begin
          head_valid <= 1'b0;
        end
      end
      if (cmd.set_found) begin
        found_q  <= 1'b1;
        dup_seen <= 1'b1;
      end
      if (cmd.insert) begin
        if (pool_full) begin
          full_q <= 1'b1;
        end else begin
          nodes_used <= nodes_used + LINK_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.seen_before   <= found_q;
      result.any_duplicate <= dup_seen;
      result.table_full    <= full_q;
      result.set_done      <= last_q;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= LINK_W'(POOL_SIZE))
    else $error("fill count beyond pool size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (nodes_used == $past(nodes_used) + LINK_W'(1)))
    else $error("insert did not allocate a node");

  a_dup_sticky: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.seen_before) |-> result.any_duplicate)
    else $error("duplicate reported without sticky flag");

  a_found_not_full: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && result.seen_before && result.table_full))
    else $error("found value also flagged as pool full");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for hash_set_duplicate_detector_core, with a directed table,
// a pool-exhaustion set and random sets checked against a behavioural hash set
// depends on hsdd_pkg, hsdd_item_if / hsdd_result_if and the core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsdd_pkg::*;

  localparam int RANDOM_ITEMS   = 120;
  localparam int CALM_ITEMS     = 30;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int N_DIRECTED     = 16;
  localparam int FULL_EXTRA     = 16;

  typedef logic [VALUE_W-1:0] word_t;
  typedef logic [LINK_W-1:0]  link_t;

  typedef struct packed {
    logic seen_before;
    logic any_duplicate;
    logic table_full;
    logic set_done;
  } verdict_t;

  typedef struct {
    word_t    value;
    bit       is_first;
    bit       is_last;
    bit       has_verdict;
    verdict_t verdict;
  } row_t;

  // directed rows; verdict bits are seen_before, any_duplicate, table_full, set_done
  row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 4'b0000},  // first value of a set
    '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 4'b1100},  // immediate repeat
    '{32'h7fff_ffff, 1'b0, 1'b0, 1'b1, 4'b0100},  // most positive
    '{32'h8000_0000, 1'b0, 1'b0, 1'b1, 4'b0100},  // most negative, shares bucket with zero
    '{32'hffff_ffff, 1'b0, 1'b0, 1'b0, 4'b0000},  // minus one, top bucket
    '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 4'b1101},  // found at the chain head, set ends
    '{32'h0000_0005, 1'b0, 1'b0, 1'b1, 4'b0100},  // set carries on past its end
    '{32'hffff_ffff, 1'b1, 1'b0, 1'b1, 4'b0000},  // new set, store and flag cleared
    '{32'h0000_0400, 1'b0, 1'b0, 1'b1, 4'b0000},  // bucket zero, stale head from before
    '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 4'b0000},  // collides, not equal
    '{32'h0000_0800, 1'b0, 1'b0, 1'b1, 4'b0000},  // third node on the same chain
    '{32'h0000_0400, 1'b0, 1'b1, 1'b1, 4'b1101},  // found at the chain tail
    '{32'h1234_5678, 1'b1, 1'b1, 1'b1, 4'b0001},  // one-item set
    '{32'hffff_ffff, 1'b1, 1'b0, 1'b0, 4'b0000},
    '{32'hffff_ffff, 1'b1, 1'b0, 1'b1, 4'b0000},  // back-to-back clear
    '{32'hffff_ffff, 1'b0, 1'b1, 1'b1, 4'b1101}
  };

  logic clk = 1'b0;
  logic rst;

  hsdd_item_if   item_ch();
  hsdd_result_if result_ch();

  hash_set_duplicate_detector_core uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural copy of the chained hash set
  link_t       head_tbl     [NUM_BUCKETS];
  word_t       node_val_tbl [POOL_SIZE];
  link_t       node_next    [POOL_SIZE];
  int unsigned fill_count;
  bit          dup_flag;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       random_sent = 0;

  // idling controls for the item and result sides
  bit calm = 1'b0;
  int gap_pct = 20;
  int stall_pct = 20;
  bit long_hold_req = 1'b0;

  function automatic void empty_store();
    foreach (head_tbl[b]) head_tbl[b] = '0;
    fill_count = 0;
    dup_flag   = 1'b0;
  endfunction

  // find the value on its bucket chain, else link it at the head if the pool has room
  function automatic verdict_t lookup_and_insert(word_t v, bit is_first, bit is_last);
    int unsigned bkt;
    int unsigned lnk;
    int unsigned idx;
    int unsigned steps = 0;
    bit          found = 1'b0;
    bit          full = 1'b0;
    verdict_t    vd;
    if (is_first) empty_store();
    bkt = v % 32'(NUM_BUCKETS);
    lnk = head_tbl[bkt];
    while (lnk != 0 && steps < fill_count) begin
      idx = lnk - 1;
      if (idx >= fill_count || idx >= POOL_SIZE) break;
      if (node_val_tbl[idx] == v) begin
        found = 1'b1;
        break;
      end
      lnk = node_next[idx];
      steps++;
    end
    if (found) begin
      dup_flag = 1'b1;
    end else if (fill_count < POOL_SIZE) begin
      node_val_tbl[fill_count] = v;
      node_next[fill_count]    = head_tbl[bkt];
      head_tbl[bkt]            = link_t'(fill_count + 1);
      fill_count++;
    end else begin
      full = 1'b1;
    end
    vd.seen_before   = found;
    vd.any_duplicate = dup_flag;
    vd.table_full    = full;
    vd.set_done      = is_last;
    return vd;
  endfunction

  function automatic void compare_field(string name, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      $error("%s: expected %0b, got %0b", name, exp_bit, got_bit);
      mismatches++;
    end
  endfunction

  function automatic void check_verdict();
    verdict_t exp_vd;
    if (pending_verdicts.size() == 0) begin
      $error("result transaction with no item outstanding");
      mismatches++;
      return;
    end
    exp_vd = pending_verdicts.pop_front();
    compare_field("seen_before",   exp_vd.seen_before,   result_ch.seen_before);
    compare_field("any_duplicate", exp_vd.any_duplicate, result_ch.any_duplicate);
    compare_field("table_full",    exp_vd.table_full,    result_ch.table_full);
    compare_field("set_done",      exp_vd.set_done,      result_ch.set_done);
  endfunction

  // offer one item, wait for the transaction, then record its expectation
  task automatic offer_item(word_t v, bit is_first, bit is_last, bit has_verdict,
                            verdict_t typed_vd);
    verdict_t vd;
    if (!calm && $urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.value        <= v;
    item_ch.first_of_set <= is_first;
    item_ch.last_of_set  <= is_last;
    do @(posedge clk); while (!item_ch.ready);
    vd = lookup_and_insert(v, is_first, is_last);
    pending_verdicts.push_back(has_verdict ? typed_vd : vd);
  endtask

  // fill the pool with distinct values, then mix new values and stored ones
  task automatic exhaust_pool();
    word_t base;
    word_t v;
    int    n_items;
    base    = $urandom();
    n_items = POOL_SIZE + FULL_EXTRA;
    for (int i = 0; i < n_items; i++) begin
      if (i < POOL_SIZE) v = base + word_t'(i);
      else if (i % 2 == 0) v = base + word_t'(POOL_SIZE + i);
      else v = base + word_t'($urandom_range(POOL_SIZE - 1));
      offer_item(v, i == 0, i == n_items - 1, 1'b0, '0);
    end
  endtask

  // one random set; broken sets place the set markers at random
  task automatic send_random_set(int len, bit broken);
    word_t members [$];
    word_t v;
    word_t crowd;
    int    pick;
    bit    is_first;
    bit    is_last;
    crowd = word_t'($urandom_range(NUM_BUCKETS - 1));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (members.size() > 0 && pick < 35)
        v = members[$urandom_range(members.size() - 1)];
      else if (pick < 55)
        v = (word_t'($urandom()) & ~word_t'(NUM_BUCKETS - 1)) | crowd;
      else if (pick < 65)
        v = word_t'($urandom_range(16)) - word_t'(8);
      else if (pick < 70)
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      else
        v = $urandom();
      members.push_back(v);
      if (broken) begin
        is_first = ($urandom_range(7) == 0);
        is_last  = ($urandom_range(5) == 0);
      end else begin
        is_first = (i == 0);
        is_last  = (i == len - 1);
      end
      offer_item(v, is_first, is_last, 1'b0, '0);
      random_sent++;
    end
  endtask

  // result side: check transactions, stall in bursts, one long hold-off
  initial begin : result_side
    int hold_cnt;
    hold_cnt        = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_verdict();
      if (long_hold_req) begin
        hold_cnt      = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (hold_cnt == 0 && !calm && $urandom_range(99) < stall_pct) begin
        hold_cnt = $urandom_range(1, 4);
      end
      result_ch.ready <= (hold_cnt == 0);
      if (hold_cnt > 0) hold_cnt--;
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // item side and end of run
  initial begin : item_side
    int  len;
    bit  hold_done;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.value        = '0;
    item_ch.first_of_set = 1'b0;
    item_ch.last_of_set  = 1'b0;
    hold_done            = 1'b0;
    empty_store();
    foreach (node_val_tbl[i]) begin
      node_val_tbl[i] = '0;
      node_next[i]    = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r])
      offer_item(directed_rows[r].value, directed_rows[r].is_first, directed_rows[r].is_last,
                 directed_rows[r].has_verdict, directed_rows[r].verdict);

    exhaust_pool();

    // random sets, idling rates changed per set, quiet at the very end
    while (random_sent < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
      calm = (RANDOM_ITEMS - random_sent <= CALM_ITEMS);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      if (!hold_done && random_sent >= 20) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
        gap_pct       = 0;
        len           = 40;
      end
      send_random_set(len, $urandom_range(9) == 0);
    end
    item_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/hsdd_pkg.sv
sv/hsdd_if.sv
sv/hsdd_ctrl.sv
sv/hsdd_datapath.sv
sv/hash_set_duplicate_detector_core.sv
tb/tb.sv
